### src/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg: shared types and constants of the 4x4 matrix vector transform
// Request and result payloads, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int DefFracBits  = 16;
  localparam int DefWordWidth = 32;
  localparam int DataW        = 32;
  localparam int CfgDataW     = 64;
  localparam int CfgIdxW      = 4;
  localparam int NumRegs      = 8;
  localparam int NumLanes     = 4;
  localparam int PipeDepth    = 3;

  localparam logic [CfgIdxW-1:0] RegRow0Cols01 = 4'd0;
  localparam logic [CfgIdxW-1:0] RegRow0Cols23 = 4'd1;
  localparam logic [CfgIdxW-1:0] RegRow1Cols01 = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRow1Cols23 = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRow2Cols01 = 4'd4;
  localparam logic [CfgIdxW-1:0] RegRow2Cols23 = 4'd5;
  localparam logic [CfgIdxW-1:0] RegRow3Cols01 = 4'd6;
  localparam logic [CfgIdxW-1:0] RegRow3Cols23 = 4'd7;

  typedef struct packed {
    logic signed [DataW-1:0] in_x;
    logic signed [DataW-1:0] in_y;
    logic signed [DataW-1:0] in_z;
    logic signed [DataW-1:0] in_w;
    logic                    point_mode;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
    logic signed [DataW-1:0] out_w;
    logic                    saturated;
  } res_t;

  // Product width covers both a full word product and a coefficient times 1.0.
  function automatic int prod_width(input int word_w, input int frac_b);
    prod_width = (word_w > frac_b + 1) ? 2 * word_w : word_w + frac_b + 1;
  endfunction

  function automatic int tot_width(input int word_w, input int frac_b);
    tot_width = prod_width(word_w, frac_b) + 2 - frac_b;
  endfunction

  // The reset matrix is the identity with 1.0 on the diagonal.
  function automatic logic [CfgDataW-1:0] cfg_reset(input logic [CfgIdxW-1:0] idx,
                                                    input int frac_b);
    logic [CfgDataW-1:0] one;
    one = CfgDataW'(1) << frac_b;
    case (idx)
      RegRow0Cols01: cfg_reset = one;
      RegRow1Cols01: cfg_reset = one << 32;
      RegRow2Cols23: cfg_reset = one;
      RegRow3Cols23: cfg_reset = one << 32;
      default:       cfg_reset = '0;
    endcase
  endfunction

endpackage

### src/m4vt_lane.sv
// ----------------------------------------------------------------------------
// m4vt_lane: one matrix row dotted with the vector
// Four products, a two-level adder tree and truncation toward zero; registers
// follow the products, the first adder level, and the second with truncation.
// ----------------------------------------------------------------------------
module m4vt_lane #(
  parameter int FRAC_BITS  = m4vt_pkg::DefFracBits,
  parameter int WORD_WIDTH = m4vt_pkg::DefWordWidth
) (
  input  logic                                                     clk_i,
  input  logic signed [WORD_WIDTH-1:0]                             coef_i [4],
  input  logic signed [WORD_WIDTH-1:0]                             vec_i  [4],
  input  logic                                                     point_i,
  output logic signed [m4vt_pkg::tot_width(WORD_WIDTH, FRAC_BITS)-1:0] tot_o
);
  import m4vt_pkg::*;

  localparam int ProdW = prod_width(WORD_WIDTH, FRAC_BITS);
  localparam int SumW  = ProdW + 2;
  localparam int TotW  = tot_width(WORD_WIDTH, FRAC_BITS);

  logic signed [ProdW-1:0] prod_d [4];
  logic signed [ProdW-1:0] prod_q [4];
  logic signed [SumW-1:0]  pair_q [2];
  logic signed [SumW-1:0]  sum_d;
  logic                    rnd;
  logic signed [TotW-1:0]  tot_d;
  logic signed [TotW-1:0]  tot_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (c == 3 && point_i) begin
        prod_d[c] = ProdW'(coef_i[c]) <<< FRAC_BITS;
      end else begin
        prod_d[c] = ProdW'(coef_i[c]) * ProdW'(vec_i[c]);
      end
    end
  end

  assign sum_d = pair_q[0] + pair_q[1];
  // A negative sum with a nonzero fraction moves up by one unit.
  assign rnd   = sum_d[SumW-1] && (|sum_d[FRAC_BITS-1:0]);
  assign tot_d = TotW'(sum_d >>> FRAC_BITS) + {{(TotW-1){1'b0}}, rnd};

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    pair_q[0] <= SumW'(prod_q[0]) + SumW'(prod_q[1]);
    pair_q[1] <= SumW'(prod_q[2]) + SumW'(prod_q[3]);
    tot_q     <= tot_d;
  end

  assign tot_o = tot_q;

endmodule

### src/m4vt_merge.sv
// ----------------------------------------------------------------------------
// m4vt_merge: saturation and result assembly
// Clamps each lane total to the word range, combines the flags and drives
// the registered result with its strobe.
// ----------------------------------------------------------------------------
module m4vt_merge #(
  parameter int FRAC_BITS  = m4vt_pkg::DefFracBits,
  parameter int WORD_WIDTH = m4vt_pkg::DefWordWidth
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     valid_i,
  input  logic signed [m4vt_pkg::tot_width(WORD_WIDTH, FRAC_BITS)-1:0] tot_i [4],
  output logic                                                     valid_o,
  output m4vt_pkg::res_t                                           res_o
);
  import m4vt_pkg::*;

  localparam int TotW = tot_width(WORD_WIDTH, FRAC_BITS);

  logic signed [WORD_WIDTH-1:0] clip [NumLanes];
  logic [NumLanes-1:0]          sat;
  logic [TotW-WORD_WIDTH:0]     hi [NumLanes];
  res_t                         res_d;
  res_t                         res_q;
  logic                         valid_q;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      hi[l]  = tot_i[l][TotW-1:WORD_WIDTH-1];
      sat[l] = !((&hi[l]) || !(|hi[l]));
      if (!sat[l]) begin
        clip[l] = tot_i[l][WORD_WIDTH-1:0];
      end else if (tot_i[l][TotW-1]) begin
        clip[l] = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
        clip[l] = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
    end
    res_d.out_x     = DataW'(clip[0]);
    res_d.out_y     = DataW'(clip[1]);
    res_d.out_z     = DataW'(clip[2]);
    res_d.out_w     = DataW'(clip[3]);
    res_d.saturated = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### src/matrix4_vector_transform_core.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_core: 4x4 matrix times 4-vector, Q16.16
// Four row lanes multiply in parallel; a merge stage saturates and packs.
// ----------------------------------------------------------------------------
// One request is taken in every cycle in which start is high; busy never rises.
// Each result appears on res_o with result_valid_o high for exactly one cycle,
// in request order, and the receiver cannot stall it. The pipeline holds one
// register after the sixteen multipliers, one after each of the two adder
// levels per row lane, and the saturating output register. Matrix writes on
// the configuration channel are always ready and should be made while no
// request is in flight.
module matrix4_vector_transform_core #(
  parameter int FRAC_BITS  = m4vt_pkg::DefFracBits,
  parameter int WORD_WIDTH = m4vt_pkg::DefWordWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  m4vt_pkg::req_t                       req_i,
  output logic                                 result_valid_o,
  output m4vt_pkg::res_t                       res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [m4vt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [m4vt_pkg::CfgDataW-1:0]        cfg_data_i
);
  import m4vt_pkg::*;

  localparam int TotW = tot_width(WORD_WIDTH, FRAC_BITS);

  logic [CfgDataW-1:0]          cfg_q [NumRegs];
  logic signed [WORD_WIDTH-1:0] vec [4];
  logic signed [WORD_WIDTH-1:0] coef [NumLanes][4];
  logic signed [TotW-1:0]       tot [NumLanes];
  logic [PipeDepth-1:0]         vld_q;
  logic                         accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= cfg_reset(CfgIdxW'(i), FRAC_BITS);
      end
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i < CfgIdxW'(NumRegs)) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], accept};
    end
  end

  assign vec[0] = req_i.in_x[WORD_WIDTH-1:0];
  assign vec[1] = req_i.in_y[WORD_WIDTH-1:0];
  assign vec[2] = req_i.in_z[WORD_WIDTH-1:0];
  assign vec[3] = req_i.in_w[WORD_WIDTH-1:0];

  for (genvar r = 0; r < NumLanes; r++) begin : g_lane
    for (genvar c = 0; c < 4; c++) begin : g_coef
      assign coef[r][c] = cfg_q[2 * r + c / 2][32 * (c % 2) +: WORD_WIDTH];
    end

    m4vt_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .coef_i  (coef[r]),
      .vec_i   (vec),
      .point_i (req_i.point_mode),
      .tot_o   (tot[r])
    );
  end

  m4vt_merge #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[PipeDepth-1]),
    .tot_i   (tot),
    .valid_o (result_valid_o),
    .res_o   (res_o)
  );

  a_result_has_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, PipeDepth + 1))
    else $error("result strobe without a request four cycles earlier");

  a_request_gets_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(PipeDepth + 1) result_valid_o)
    else $error("request did not produce a result after four cycles");

  a_pipe_matches_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PipeDepth-1] |=> result_valid_o)
    else $error("last lane stage valid was not followed by a result strobe");

endmodule

### bench/matrix4_vector_transform_core_tb.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_core_tb: self-checking bench of the vertex transform
// A short table of directed vectors runs first: identity reset values, full
// scale and most negative coefficients, saturation, and rounding toward zero.
// Random matrix settings and random vectors follow, with the sender idling at
// several rates. Every result is compared field by field with a prediction.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_core_tb;
  import m4vt_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int FracBits      = DefFracBits;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 185;
  localparam int DrainCycles   = PipeDepth + 4;
  localparam int CycleLimit    = 400000;
  localparam int MaxPrinted    = 40;
  localparam int NumDirected   = 20;
  localparam logic [CfgIdxW-1:0] FirstBadIdx = CfgIdxW'(NumRegs);
  localparam logic [CfgIdxW-1:0] LastBadIdx  = '1;
  localparam logic signed [67:0] LaneMax = (68'sd1 <<< 31) - 68'sd1;
  localparam logic signed [67:0] LaneMin = -(68'sd1 <<< 31);
  localparam logic [DataW-1:0] OneQ   = 32'h0001_0000;
  localparam logic [DataW-1:0] MaxQ   = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] MinQ   = 32'h8000_0000;
  localparam logic [DataW-1:0] MinusU = 32'hFFFF_FFFF;

  typedef struct {
    int   mat;
    req_t vec;
    bit   typed;
    res_t want;
  } vec_case_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  req_t                req_i       = '0;
  logic                result_valid_o;
  res_t                res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  logic [CfgDataW-1:0] mat_regs [NumRegs];
  res_t                xforms_due [$];
  int unsigned         cycles       = 0;
  int unsigned         mismatches   = 0;
  int unsigned         vecs_sent    = 0;
  int unsigned         results_seen = 0;
  int unsigned         reg_writes   = 0;
  int unsigned         settings     = 0;

  // Uniform fill values of the directed matrices; matrix 0 is the reset identity.
  logic [CfgDataW-1:0] dir_fill [1:3] = '{
    64'h7FFF_FFFF_7FFF_FFFF,
    64'h8000_0000_8000_0000,
    64'hFFFF_8000_0000_8000
  };

  vec_case_t dir_cases [NumDirected] = '{
    '{0, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1,
         '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
    '{0, '{MaxQ, MinQ, MinusU, 32'h1, 1'b0}, 1'b1,
         '{MaxQ, MinQ, MinusU, 32'h1, 1'b0}},
    '{0, '{MinQ, MaxQ, 32'h1, MinusU, 1'b0}, 1'b1,
         '{MinQ, MaxQ, 32'h1, MinusU, 1'b0}},
    '{0, '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0}, 1'b1,
         '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0}},
    '{0, '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hDEAD_BEEF, 1'b1}, 1'b1,
         '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, OneQ, 1'b0}},
    '{0, '{32'h0, 32'h0, 32'h0, MaxQ, 1'b1}, 1'b1,
         '{32'h0, 32'h0, 32'h0, OneQ, 1'b0}},
    '{1, '{MaxQ, MaxQ, MaxQ, MaxQ, 1'b0}, 1'b1,
         '{MaxQ, MaxQ, MaxQ, MaxQ, 1'b1}},
    '{1, '{MinQ, MinQ, MinQ, MinQ, 1'b0}, 1'b1,
         '{MinQ, MinQ, MinQ, MinQ, 1'b1}},
    '{1, '{32'h0, 32'h0, 32'h0, MinQ, 1'b1}, 1'b1,
         '{MaxQ, MaxQ, MaxQ, MaxQ, 1'b0}},
    '{1, '{OneQ, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{2, '{MaxQ, MaxQ, MaxQ, MaxQ, 1'b0}, 1'b1,
         '{MinQ, MinQ, MinQ, MinQ, 1'b1}},
    '{2, '{MinQ, MinQ, MinQ, MinQ, 1'b0}, 1'b1,
         '{MaxQ, MaxQ, MaxQ, MaxQ, 1'b1}},
    '{2, '{32'h0, 32'h0, 32'h0, MaxQ, 1'b1}, 1'b1,
         '{MinQ, MinQ, MinQ, MinQ, 1'b0}},
    '{2, '{MinusU, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{3, '{32'h1, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{3, '{MinusU, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{3, '{32'h3, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{3, '{32'hFFFF_FFFD, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{3, '{32'h0, 32'h3, 32'h0, 32'h5555_5555, 1'b1}, 1'b0, '0},
    '{3, '{MaxQ, MinQ, MaxQ, MinQ, 1'b0}, 1'b0, '0}
  };

  matrix4_vector_transform_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void reset_matrix();
    foreach (mat_regs[i]) mat_regs[i] = '0;
    mat_regs[RegRow0Cols01] = CfgDataW'(OneQ);
    mat_regs[RegRow1Cols01] = {OneQ, 32'h0};
    mat_regs[RegRow2Cols23] = CfgDataW'(OneQ);
    mat_regs[RegRow3Cols23] = {OneQ, 32'h0};
  endfunction

  // Exact four-term dot product per row, truncated toward zero, then clamped.
  function automatic res_t transform_vec(input req_t vec);
    logic signed [DataW-1:0] comp [NumLanes];
    logic signed [DataW-1:0] lane [NumLanes];
    logic [CfgDataW-1:0]     word;
    logic signed [DataW-1:0] coef;
    logic signed [67:0]      acc;
    logic signed [67:0]      term;
    logic                    sat;
    res_t                    o;
    comp[0] = vec.in_x;
    comp[1] = vec.in_y;
    comp[2] = vec.in_z;
    comp[3] = vec.in_w;
    sat = 1'b0;
    for (int row = 0; row < NumLanes; row++) begin
      acc = '0;
      for (int col = 0; col < NumLanes; col++) begin
        word = mat_regs[2 * row + col / 2];
        coef = (col % 2 == 1) ? word[63:32] : word[31:0];
        term = 68'(coef);
        if (col == NumLanes - 1 && vec.point_mode) begin
          term = term <<< FracBits;
        end else begin
          term = term * comp[col];
        end
        acc = acc + term;
      end
      if (acc < 0) begin
        acc = -((-acc) >>> FracBits);
      end else begin
        acc = acc >>> FracBits;
      end
      if (acc > LaneMax) begin
        acc = LaneMax;
        sat = 1'b1;
      end else if (acc < LaneMin) begin
        acc = LaneMin;
        sat = 1'b1;
      end
      lane[row] = acc[DataW-1:0];
    end
    o.out_x     = lane[0];
    o.out_y     = lane[1];
    o.out_z     = lane[2];
    o.out_w     = lane[3];
    o.saturated = sat;
    return o;
  endfunction

  function automatic logic [DataW-1:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom_range(32'h7_FFFF) - 32'h4_0000;
    if (pick < 88) return $urandom;
    case ($urandom_range(3))
      0:       return MaxQ;
      1:       return MinQ;
      2:       return '0;
      default: return OneQ;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_comp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return $urandom_range(32'h1FF_FFFF) - 32'h100_0000;
    if (pick < 85) return $urandom;
    case ($urandom_range(4))
      0:       return MaxQ;
      1:       return MinQ;
      2:       return MinusU;
      3:       return 32'h1;
      default: return '0;
    endcase
  endfunction

  function automatic req_t rand_vec();
    req_t v;
    v.in_x       = rand_comp();
    v.in_y       = rand_comp();
    v.in_z       = rand_comp();
    v.in_w       = rand_comp();
    v.point_mode = 1'($urandom_range(1));
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    end
  endtask

  task automatic check_xform(input res_t got);
    res_t want;
    want = xforms_due.pop_front();
    if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
    if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
    if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
    if (got.out_w !== want.out_w) report_mismatch("out_w", got.out_w, want.out_w);
    if (got.saturated !== want.saturated) begin
      report_mismatch("saturated", DataW'(got.saturated), DataW'(want.saturated));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (xforms_due.size() == 0) begin
        report_mismatch("result with no request pending", res_o.out_x, '0);
      end else begin
        check_xform(res_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results pending",
               cycles, xforms_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_vec(input req_t vec, input res_t want, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= vec;
    do @(posedge clk_i); while (busy);
    xforms_due.push_back(want);
    vecs_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < FirstBadIdx) mat_regs[idx[2:0]] = data;
    reg_writes++;
  endtask

  // Loads a full matrix once no request is in flight, then writes an unmapped index.
  task automatic load_matrix(input logic [CfgDataW-1:0] vals [NumRegs]);
    start <= 1'b0;
    while (xforms_due.size() != 0) @(posedge clk_i);
    for (int i = 0; i < NumRegs; i++) write_reg(CfgIdxW'(i), vals[i]);
    write_reg(CfgIdxW'($urandom_range(FirstBadIdx, LastBadIdx)),
              {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [CfgDataW-1:0] vals [NumRegs];
    req_t                vec;
    int                  prev_mat;
    int                  idle_pct;
    reset_matrix();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_mat = 0;
    foreach (dir_cases[k]) begin
      if (dir_cases[k].mat != prev_mat) begin
        foreach (vals[i]) vals[i] = dir_fill[dir_cases[k].mat];
        load_matrix(vals);
        prev_mat = dir_cases[k].mat;
      end
      send_vec(dir_cases[k].vec,
               dir_cases[k].typed ? dir_cases[k].want : transform_vec(dir_cases[k].vec),
               0);
    end

    for (int p = 0; p < NumPhases; p++) begin
      foreach (vals[i]) vals[i] = {rand_coef(), rand_coef()};
      load_matrix(vals);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 71;
        default: idle_pct = 19;
      endcase
      repeat (ItemsPerPhase) begin
        vec = rand_vec();
        send_vec(vec, transform_vec(vec), idle_pct);
      end
    end
    start <= 1'b0;

    while (xforms_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d vectors through %0d matrix settings (%0d register writes).",
             vecs_sent, settings, reg_writes);
    $display("Checked %0d results; %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
src/m4vt_pkg.sv
src/m4vt_lane.sv
src/m4vt_merge.sv
src/matrix4_vector_transform_core.sv
bench/matrix4_vector_transform_core_tb.sv
